/* sv/lsb_first_bit_packer_unit_macros.svh */
// Assertion helpers for the bit packer.
`ifndef LSB_FIRST_BIT_PACKER_UNIT_MACROS_SVH
`define LSB_FIRST_BIT_PACKER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LBP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbp: implication check failed");

// Next-cycle implication, checked out of reset.
`define LBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbp: next-cycle check failed");

`endif

/* sv/lbp_pkg.sv */
`timescale 1ns / 1ps

package lbp_pkg;

    localparam int WORD_W     = 32;
    localparam int CMD_W      = 2;
    localparam int NBITS_W    = 6;
    localparam int CNT_W      = 5;
    localparam int CAP_REG_W  = 17;
    localparam int BITS_OUT_W = 22;
    localparam int INDEX_W    = 16;

    localparam logic [CAP_REG_W-1:0] CAP_RESET  = 17'd65536;
    localparam logic [NBITS_W-1:0]   WORD_BITS  = 6'd32;
    localparam logic [2:0]           BYTE_MASK  = 3'd7;
    localparam logic [CNT_W-1:0]     WORD_MASK  = 5'd31;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_BITS  = 2'd0,
        CMD_BEGIN_BYTES = 2'd1,
        CMD_FLUSH       = 2'd2,
        CMD_RESTART     = 2'd3
    } lbp_cmd_e;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [WORD_W-1:0]  value;
        logic [NBITS_W-1:0] bit_count;
    } lbp_item_t;

    typedef struct packed {
        logic                  status;
        logic                  word_valid;
        logic [WORD_W-1:0]     packed_word;
        logic [INDEX_W-1:0]    word_index;
        logic [BITS_OUT_W-1:0] bits_used;
        logic [BITS_OUT_W-1:0] bits_left;
    } lbp_result_t;

endpackage

/* sv/lbp_cmd_if.sv */
`timescale 1ns / 1ps

interface lbp_cmd_if;
    import lbp_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [WORD_W-1:0]  value;
    logic [NBITS_W-1:0] bit_count;

    modport source (output valid, command, value, bit_count, input ready);
    modport sink   (input valid, command, value, bit_count, output ready);
endinterface

/* sv/lbp_res_if.sv */
`timescale 1ns / 1ps

interface lbp_res_if;
    import lbp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  status;
    logic                  word_valid;
    logic [WORD_W-1:0]     packed_word;
    logic [INDEX_W-1:0]    word_index;
    logic [BITS_OUT_W-1:0] bits_used;
    logic [BITS_OUT_W-1:0] bits_left;

    modport source (output valid, status, word_valid, packed_word, word_index,
                    bits_used, bits_left, input ready);
    modport sink   (input valid, status, word_valid, packed_word, word_index,
                    bits_used, bits_left, output ready);
endinterface

/* sv/lbp_step.sv */
`timescale 1ns / 1ps

// Next-state and result logic for one command.
module lbp_step #(
    parameter int USED_W = 22
) (
    input  lbp_pkg::lbp_item_t         item,
    input  logic [31:0]                pend_bits,
    input  logic [4:0]                 pend_cnt,
    input  logic [USED_W-1:0]          used,
    input  logic [USED_W-1:0]          cap_bits,
    output logic [31:0]                pend_bits_next,
    output logic [4:0]                 pend_cnt_next,
    output logic [USED_W-1:0]          used_next,
    output lbp_pkg::lbp_result_t       result
);
    import lbp_pkg::*;

    localparam int SUM_W = ((USED_W > WORD_W + 3) ? USED_W : WORD_W + 3) + 1;

    logic [NBITS_W-1:0] nbits;
    logic [32:0]        mask33;
    logic [SUM_W-1:0]   used_x;
    logic [SUM_W-1:0]   cap_x;
    logic [SUM_W-1:0]   index_x;
    logic [3:0]         pad_n;
    logic               app_en;
    logic [NBITS_W-1:0] app_n;
    logic [WORD_W-1:0]  app_v;
    logic [63:0]        acc;
    logic [NBITS_W-1:0] cnt6;

    always_comb
    begin
        nbits   = (item.bit_count > WORD_BITS) ? WORD_BITS : item.bit_count;
        mask33  = (33'd1 << nbits) - 33'd1;
        used_x  = SUM_W'(used);
        cap_x   = SUM_W'(cap_bits);
        pad_n   = 4'd8 - {1'b0, used[2:0] & BYTE_MASK};

        pend_bits_next = pend_bits;
        pend_cnt_next  = pend_cnt;
        used_next      = used;
        result         = '0;

        app_en = 1'b0;
        app_n  = '0;
        app_v  = '0;

        case (item.command)
            CMD_WRITE_BITS:
            begin
                if (used_x + SUM_W'(nbits) > cap_x)
                    result.status = 1'b1;
                else
                begin
                    app_en = 1'b1;
                    app_n  = nbits;
                    app_v  = item.value & mask33[31:0];
                end
            end
            CMD_BEGIN_BYTES:
            begin
                if (used_x + SUM_W'({item.value, 3'b000}) > cap_x)
                    result.status = 1'b1;
                else if (used[2:0] != 3'd0 && used_x + SUM_W'(pad_n) <= cap_x)
                begin
                    // zero padding up to the next byte boundary
                    app_en = 1'b1;
                    app_n  = NBITS_W'(pad_n);
                end
            end
            CMD_FLUSH:
            begin
                if (pend_cnt != '0)
                begin
                    result.word_valid  = 1'b1;
                    result.packed_word = pend_bits;
                    used_next      = used + USED_W'(WORD_BITS - {1'b0, pend_cnt});
                    pend_bits_next = '0;
                    pend_cnt_next  = '0;
                end
            end
            default:
            begin
                pend_bits_next = '0;
                pend_cnt_next  = '0;
                used_next      = '0;
            end
        endcase

        // shared append path; bits above pend_cnt are always zero
        acc  = {32'd0, pend_bits} | ({32'd0, app_v} << pend_cnt);
        cnt6 = {1'b0, pend_cnt} + app_n;
        if (app_en)
        begin
            used_next     = used + USED_W'(app_n);
            pend_cnt_next = cnt6[4:0] & WORD_MASK;
            if (cnt6[5])
            begin
                result.word_valid  = 1'b1;
                result.packed_word = acc[31:0];
                pend_bits_next     = acc[63:32];
            end
            else
                pend_bits_next = acc[31:0];
        end

        index_x = SUM_W'(used_next >> 5) - SUM_W'(1);
        if (result.word_valid)
            result.word_index = index_x[INDEX_W-1:0];

        result.bits_used = BITS_OUT_W'(SUM_W'(used_next));
        if (used_next > cap_bits)
            result.bits_left = '0;
        else
            result.bits_left = BITS_OUT_W'(SUM_W'(cap_bits - used_next));
    end

endmodule

/* sv/lsb_first_bit_packer_unit.sv */
`timescale 1ns / 1ps

// LSB-first bit packer: appends fields of 0..32 bits into 32-bit words,
// bit 0 of each word is the earliest bit (store words little-endian).
// Channels: cmd carries command/value/bit_count, res returns one result
// per command (status, optional completed word with its buffer index,
// bits used and bits left). Transfer = valid && ready on either channel.
// cfg_wr_en/cfg_wr_data set the capacity in words; write only when idle.
// A command transferred on cmd goes into the input register and then into
// the result register, from which res shows it. One command per cycle
// sustained while res is ready: the input register and the result register
// each hold one item, and the combinational state update (shift/OR plus capacity compares) sets the rate.
// When res stalls, the result register holds and the input register
// still takes one more command; cmd.ready drops once both are full.
// Reset clears the packer state and the pipeline and sets the capacity to
// 65536 words. A restart command clears the state but keeps the capacity.
module lsb_first_bit_packer_unit #(
    parameter int MAX_WORDS = 65536
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [lbp_pkg::CAP_REG_W-1:0]    cfg_wr_data,
    lbp_cmd_if.sink                          cmd,
    lbp_res_if.source                        res
);
    import lbp_pkg::*;
    `include "lsb_first_bit_packer_unit_macros.svh"

    localparam int USED_W = $clog2(MAX_WORDS) + 6;
    localparam int CW_W   = (USED_W > CAP_REG_W) ? USED_W : CAP_REG_W;

    logic [CAP_REG_W-1:0] cap_words_reg;
    logic [CW_W-1:0]      cap_eff;
    logic [USED_W-1:0]    cap_bits;

    logic                 s1_valid_reg;
    lbp_item_t            s1_item_reg;
    logic                 out_valid_reg;
    lbp_result_t          out_res_reg;

    logic [31:0]          pend_bits_reg;
    logic [4:0]           pend_cnt_reg;
    logic [USED_W-1:0]    used_reg;
    logic [31:0]          pend_bits_next;
    logic [4:0]           pend_cnt_next;
    logic [USED_W-1:0]    used_next;
    lbp_result_t          res_next;

    logic                 s1_adv;
    logic                 cmd_xfer;

    always_comb
    begin
        cap_eff = (CW_W'(cap_words_reg) > CW_W'(MAX_WORDS)) ? CW_W'(MAX_WORDS)
                                                             : CW_W'(cap_words_reg);
        cap_bits = {cap_eff[USED_W-6:0], 5'b00000};
    end

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || !out_valid_reg || res.ready;
    assign cmd_xfer  = cmd.valid && cmd.ready;

    lbp_step #(
        .USED_W (USED_W)
    ) u_step (
        .item           (s1_item_reg),
        .pend_bits      (pend_bits_reg),
        .pend_cnt       (pend_cnt_reg),
        .used           (used_reg),
        .cap_bits       (cap_bits),
        .pend_bits_next (pend_bits_next),
        .pend_cnt_next  (pend_cnt_next),
        .used_next      (used_next),
        .result         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_words_reg <= CAP_RESET;
        else if (cfg_wr_en)
            cap_words_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (cmd_xfer)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            s1_item_reg.command   <= cmd.command;
            s1_item_reg.value     <= cmd.value;
            s1_item_reg.bit_count <= cmd.bit_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            used_reg      <= used_next;
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            out_res_reg <= res_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.status      = out_res_reg.status;
    assign res.word_valid  = out_res_reg.word_valid;
    assign res.packed_word = out_res_reg.packed_word;
    assign res.word_index  = out_res_reg.word_index;
    assign res.bits_used   = out_res_reg.bits_used;
    assign res.bits_left   = out_res_reg.bits_left;

    // pending count tracks the used total modulo the word size
    `LBP_ASSERT_IMPL(a_cnt_mod, clk, rst_n, 1'b1, pend_cnt_reg == used_reg[4:0])
    // nothing stored above the pending count
    `LBP_ASSERT_IMPL(a_pend_clean, clk, rst_n, 1'b1, (pend_bits_reg >> pend_cnt_reg) == 32'd0)
    // a rejected command never completes a word
    `LBP_ASSERT_IMPL(a_rej_noword, clk, rst_n, out_valid_reg && out_res_reg.status,
                     !out_res_reg.word_valid)
    // a full pipe with a stalled receiver keeps the state frozen
    `LBP_ASSERT_NEXT(a_stall_hold, clk, rst_n,
                     s1_valid_reg && out_valid_reg && !res.ready,
                     used_reg == $past(used_reg) && pend_bits_reg == $past(pend_bits_reg))

endmodule

/* bench/tb_lsb_first_bit_packer_unit.sv */
`timescale 1ns / 1ps

module tb_lsb_first_bit_packer_unit;
    import lbp_pkg::*;

    localparam int PACK_MAX_WORDS = 65536;
    localparam int MAX_REPORTS    = 30;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 155;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en;
    logic [CAP_REG_W-1:0] cfg_wr_data;

    lbp_cmd_if cmd_ch ();
    lbp_res_if res_ch ();

    lsb_first_bit_packer_unit #(
        .MAX_WORDS (PACK_MAX_WORDS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd_ch),
        .res         (res_ch)
    );

    always #2 clk = ~clk;

    // packer state as the testbench sees it
    logic [CAP_REG_W-1:0] cap_words;
    logic [WORD_W-1:0]    pend_bits = '0;
    logic [CNT_W-1:0]     pend_cnt = '0;
    int unsigned          used_total = 0;

    lbp_item_t   pending_items[$];
    lbp_result_t expected_results[$];

    lbp_item_t   next_item;
    lbp_result_t exp_res;

    int unsigned items_queued;
    int unsigned results_seen;
    int unsigned error_count;
    int unsigned words_predicted;
    int unsigned rejects_predicted;
    int unsigned capacity_writes;

    bit sender_idle;
    bit sink_stall;
    int burst_left;
    int gap_left;
    int sink_tick;
    int stall_len;
    bit long_stall;

    // Appends a field that is known to fit; completes a word at 32 pending bits.
    function automatic void pack_field(input logic [WORD_W-1:0] v, input int unsigned n,
                                       inout lbp_result_t r);
        logic [63:0] acc;
        int unsigned cnt;
        acc = {32'd0, pend_bits} | ((((64'd1 << n) - 64'd1) & {32'd0, v}) << pend_cnt);
        cnt = pend_cnt + n;
        if (cnt >= 32) begin
            r.word_valid  = 1'b1;
            r.packed_word = acc[31:0];
            acc = acc >> 32;
            cnt = cnt - 32;
        end
        pend_bits  = acc[31:0];
        pend_cnt   = cnt[CNT_W-1:0];
        used_total = used_total + n;
    endfunction

    function automatic lbp_result_t predict_packer(lbp_item_t it);
        lbp_result_t       r;
        int unsigned       n;
        int unsigned       pad;
        longint unsigned   cap_bits;
        r = '0;
        cap_bits = longint'(cap_words > PACK_MAX_WORDS ? PACK_MAX_WORDS : cap_words) * 32;
        n = (it.bit_count > 32) ? 32 : it.bit_count;
        case (it.command)
            CMD_WRITE_BITS: begin
                if (longint'(used_total) + n > cap_bits)
                    r.status = 1'b1;
                else
                    pack_field(it.value, n, r);
            end
            CMD_BEGIN_BYTES: begin
                // room check ignores the padding; padding only if it still fits
                if (longint'(used_total) + (longint'(it.value) << 3) > cap_bits) begin
                    r.status = 1'b1;
                end
                else begin
                    pad = used_total % 8;
                    if (pad != 0 && longint'(used_total) + (8 - pad) <= cap_bits)
                        pack_field('0, 8 - pad, r);
                end
            end
            CMD_FLUSH: begin
                if (pend_cnt != 0) begin
                    r.word_valid  = 1'b1;
                    r.packed_word = pend_bits;
                    used_total    = used_total + 32 - pend_cnt;
                    pend_bits     = '0;
                    pend_cnt      = '0;
                end
            end
            default: begin
                pend_bits  = '0;
                pend_cnt   = '0;
                used_total = 0;
            end
        endcase
        if (r.word_valid) begin
            r.word_index = INDEX_W'((used_total >> 5) - 1);
            words_predicted++;
        end
        if (r.status)
            rejects_predicted++;
        r.bits_used = used_total[BITS_OUT_W-1:0];
        r.bits_left = (longint'(used_total) > cap_bits) ? '0
                                                        : BITS_OUT_W'(cap_bits - used_total);
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            if (error_count < MAX_REPORTS)
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // driver: bursts of transfers, with random gaps while sender_idle is set
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cmd_ch.valid     <= 1'b0;
            cmd_ch.command   <= '0;
            cmd_ch.value     <= '0;
            cmd_ch.bit_count <= '0;
            burst_left       <= 0;
            gap_left         <= 0;
        end
        else begin
            if (cmd_ch.valid && cmd_ch.ready)
                expected_results.push_back(predict_packer(
                    lbp_item_t'({cmd_ch.command, cmd_ch.value, cmd_ch.bit_count})));
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (gap_left != 0) begin
                    cmd_ch.valid <= 1'b0;
                    gap_left     <= gap_left - 1;
                end
                else if (pending_items.size() != 0) begin
                    next_item        = pending_items.pop_front();
                    cmd_ch.valid     <= 1'b1;
                    cmd_ch.command   <= next_item.command;
                    cmd_ch.value     <= next_item.value;
                    cmd_ch.bit_count <= next_item.bit_count;
                    if (sender_idle && burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= $urandom_range(1, 6);
                    end
                    else if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end
                end
                else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transfer; ready follows its own stall pattern
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            sink_tick    <= 0;
            stall_len    <= 0;
            long_stall   <= 1'b0;
        end
        else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    if (error_count < MAX_REPORTS)
                        $error("result transfer with nothing expected");
                    error_count++;
                end
                else begin
                    exp_res = expected_results.pop_front();
                    check_field("status", exp_res.status, res_ch.status);
                    check_field("word_valid", exp_res.word_valid, res_ch.word_valid);
                    check_field("packed_word", exp_res.packed_word, res_ch.packed_word);
                    check_field("word_index", exp_res.word_index, res_ch.word_index);
                    check_field("bits_used", exp_res.bits_used, res_ch.bits_used);
                    check_field("bits_left", exp_res.bits_left, res_ch.bits_left);
                end
            end
            sink_tick <= sink_tick + 1;
            if (sink_tick % 48 == 0) begin
                stall_len  <= $urandom_range(0, 8);
                long_stall <= ($urandom_range(0, 7) == 0);
            end
            res_ch.ready <= !sink_stall || (!long_stall && (sink_tick % 10 >= stall_len));
        end
    end

    task automatic add_item(lbp_cmd_e op, logic [WORD_W-1:0] v, logic [NBITS_W-1:0] n);
        pending_items.push_back(lbp_item_t'{command: op, value: v, bit_count: n});
        items_queued++;
    endtask

    // waits until every queued item has come back as a result
    task automatic wait_drained();
        while (results_seen < items_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_REG_W-1:0] words);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= words;
        cap_words   = words;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        capacity_writes++;
    endtask

    task automatic queue_random_items(int unsigned count);
        int unsigned k;
        int unsigned run;
        int unsigned pick;
        k = 0;
        while (k < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                // byte run: room check, then that many 8-bit fields
                run = $urandom_range(0, 6);
                add_item(CMD_BEGIN_BYTES, run, NBITS_W'($urandom_range(0, 63)));
                for (int unsigned b = 0; b < run; b++)
                    add_item(CMD_WRITE_BITS, $urandom, 6'd8);
                k = k + run + 1;
            end
            else begin
                if (pick < 60)
                    add_item(CMD_WRITE_BITS, $urandom,
                             NBITS_W'(($urandom_range(0, 9) == 0) ? $urandom_range(33, 63)
                                                                  : $urandom_range(0, 32)));
                else if (pick < 68)
                    add_item(CMD_WRITE_BITS, $urandom, 6'd32);
                else if (pick < 78)
                    add_item(CMD_BEGIN_BYTES,
                             $urandom_range(0, 1) ? $urandom_range(0, 16) : $urandom,
                             NBITS_W'($urandom_range(0, 63)));
                else if (pick < 92)
                    add_item(CMD_FLUSH, $urandom, NBITS_W'($urandom_range(0, 63)));
                else
                    add_item(CMD_RESTART, $urandom, NBITS_W'($urandom_range(0, 63)));
                k++;
            end
        end
    endtask

    initial begin
        int unsigned chunk;
        int unsigned left;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        cap_words        = CAP_RESET;
        sender_idle      = 1'b1;
        sink_stall       = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset capacity: widths, word completion, padding, flushes, byte run reject
        add_item(CMD_WRITE_BITS, 32'hFFFF_FFFF, 6'd0);
        add_item(CMD_WRITE_BITS, 32'hFFFF_FFFF, 6'd32);
        add_item(CMD_WRITE_BITS, 32'hDEAD_BEEF, 6'd63);
        add_item(CMD_WRITE_BITS, 32'h0000_0005, 6'd3);
        add_item(CMD_WRITE_BITS, 32'h7FFF_FFFF, 6'd31);
        add_item(CMD_BEGIN_BYTES, 32'd2, 6'd0);
        add_item(CMD_WRITE_BITS, 32'h0000_0001, 6'd1);
        add_item(CMD_FLUSH, 32'd0, 6'd0);
        add_item(CMD_FLUSH, 32'd0, 6'd0);
        add_item(CMD_BEGIN_BYTES, 32'd0, 6'd0);
        add_item(CMD_WRITE_BITS, 32'h3FFF_FFFF, 6'd30);
        add_item(CMD_BEGIN_BYTES, 32'd1, 6'd0);
        add_item(CMD_BEGIN_BYTES, 32'hFFFF_FFFF, 6'd0);
        add_item(CMD_RESTART, 32'd0, 6'd0);
        wait_drained();

        // register above the limit saturates
        set_capacity(17'h1FFFF);
        add_item(CMD_WRITE_BITS, 32'hA5A5_A5A5, 6'd17);
        add_item(CMD_FLUSH, 32'd0, 6'd0);
        wait_drained();

        // zero capacity with a word already used: every command is rejected
        set_capacity('0);
        add_item(CMD_WRITE_BITS, 32'h0000_0001, 6'd1);
        add_item(CMD_WRITE_BITS, 32'd0, 6'd0);
        add_item(CMD_BEGIN_BYTES, 32'd0, 6'd0);
        wait_drained();

        set_capacity(17'd1);
        add_item(CMD_WRITE_BITS, 32'h000A_BCDE, 6'd20);
        add_item(CMD_WRITE_BITS, 32'h0000_0FFF, 6'd12);
        add_item(CMD_WRITE_BITS, 32'h0000_0001, 6'd1);
        wait_drained();

        // capacity lowered below what is already used
        set_capacity('0);
        add_item(CMD_WRITE_BITS, 32'd0, 6'd0);
        add_item(CMD_BEGIN_BYTES, 32'd0, 6'd0);
        add_item(CMD_FLUSH, 32'd0, 6'd0);
        add_item(CMD_RESTART, 32'd0, 6'd0);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: set_capacity(CAP_REG_W'($urandom_range(0, 4)));
                1: set_capacity(CAP_REG_W'($urandom_range(5, 64)));
                2: set_capacity(CAP_REG_W'($urandom_range(65536, 131071)));
                default: set_capacity(CAP_REG_W'($urandom_range(0, 131071)));
            endcase
            sender_idle = (p != 0) && ($urandom_range(0, 3) != 0);
            sink_stall  = (p != 0) && ($urandom_range(0, 3) != 0);
            left = PHASE_ITEMS;
            while (left > 0) begin
                chunk = $urandom_range(10, 60);
                if (chunk > left)
                    chunk = left;
                queue_random_items(chunk);
                left = left - chunk;
                // hold the sender now and then until the block is empty
                if ($urandom_range(0, 3) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        $display("Ran %0d commands under %0d capacity settings.", items_queued, capacity_writes);
        $display("Expected %0d emitted words and %0d rejected commands.",
                 words_predicted, rejects_predicted);
        if (error_count == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
